### sv/imu_offset_calibrate_and_correct_defines.svh
// Assertion macros shared by the IMU offset calibration RTL.
// Depends on nothing; taken in by the files that carry assertions.
`ifndef IMU_OFFSET_CALIBRATE_AND_CORRECT_DEFINES_SVH
`define IMU_OFFSET_CALIBRATE_AND_CORRECT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IMUOC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IMUOC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### sv/imuoc_pkg.sv
// Package for the IMU offset calibration block: types, axis indexes,
// register indexes and reset values. Depends on nothing.
package imuoc_pkg;

  localparam int AXES         = 6;
  localparam int SAMPLE_W     = 16;
  localparam int LIMIT_W      = 15;
  localparam int NEGATE_W     = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int WIDE_W       = 19;  // raw - offset, negated, plus gravity
  localparam int CAL_SHIFT_DEF = 4;

  localparam int AXIS_ACCEL_Z = 2;
  localparam int ACCEL_AXES   = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;
  typedef logic [LIMIT_W-1:0]         limit_t;

  localparam wide_t WIDE_MAX = 19'sd32767;
  localparam wide_t WIDE_MIN = -19'sd32768;
  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  typedef enum logic {
    REQ_CAL     = 1'b0,
    REQ_MEASURE = 1'b1
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_LIMIT   = 3'd0,
    REG_GYRO_LIMIT    = 3'd1,
    REG_GRAVITY       = 3'd2,
    REG_AXIS_NEGATE   = 3'd3
  } reg_idx_t;

  localparam limit_t              ACCEL_LIMIT_RST = 15'd500;
  localparam limit_t              GYRO_LIMIT_RST  = 15'd5000;
  localparam sample_t             GRAVITY_RST     = 16'sd256;
  localparam logic [NEGATE_W-1:0] NEGATE_RST      = 6'd49;

  // Per-axis settings handed to one correction lane.
  typedef struct packed {
    logic    negate;
    sample_t gravity;
    limit_t  limit;
  } axis_cfg_t;

endpackage

### sv/imuoc_if.sv
// Channel interfaces of the IMU offset calibration block: input frame,
// corrected result and register write. Depends on imuoc_pkg.
interface imuoc_frame_if;
  import imuoc_pkg::*;
  logic    valid;
  logic    ready;
  logic    req_type;
  sample_t accel_x_raw;
  sample_t accel_y_raw;
  sample_t accel_z_raw;
  sample_t roll_rate_raw;
  sample_t pitch_rate_raw;
  sample_t yaw_rate_raw;

  modport source(output valid, req_type, accel_x_raw, accel_y_raw, accel_z_raw,
                 roll_rate_raw, pitch_rate_raw, yaw_rate_raw, input ready);
  modport sink(input valid, req_type, accel_x_raw, accel_y_raw, accel_z_raw,
               roll_rate_raw, pitch_rate_raw, yaw_rate_raw, output ready);
endinterface

interface imuoc_result_if;
  import imuoc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t accel_x_out;
  sample_t accel_y_out;
  sample_t accel_z_out;
  sample_t roll_rate_out;
  sample_t pitch_rate_out;
  sample_t yaw_rate_out;
  logic    accel_over_limit;
  logic    gyro_over_limit;

  modport source(output valid, accel_x_out, accel_y_out, accel_z_out,
                 roll_rate_out, pitch_rate_out, yaw_rate_out, accel_over_limit,
                 gyro_over_limit, input ready);
  modport sink(input valid, accel_x_out, accel_y_out, accel_z_out,
               roll_rate_out, pitch_rate_out, yaw_rate_out, accel_over_limit,
               gyro_over_limit, output ready);
endinterface

interface imuoc_cfg_if;
  import imuoc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### sv/imuoc_axis.sv
// One correction lane: offset subtract, optional negate, gravity add,
// saturation test against the limit and clamp to 16 bits. Uses imuoc_pkg.
module imuoc_axis (
  input  imuoc_pkg::sample_t   raw,
  input  imuoc_pkg::sample_t   offset,
  input  imuoc_pkg::axis_cfg_t cfg,
  output imuoc_pkg::sample_t   value,
  output logic                 sat
);
  import imuoc_pkg::*;

  wide_t diff;
  wide_t signed_diff;
  wide_t corrected;
  wide_t lim;

  assign diff        = WIDE_W'(raw) - WIDE_W'(offset);
  assign signed_diff = cfg.negate ? -diff : diff;
  assign corrected   = signed_diff + WIDE_W'(cfg.gravity);
  assign lim         = $signed({{(WIDE_W-LIMIT_W){1'b0}}, cfg.limit});

  assign sat = (corrected > lim) || (corrected < -lim);

  always_comb begin
    if (corrected > WIDE_MAX) begin
      value = SAMPLE_MAX;
    end else if (corrected < WIDE_MIN) begin
      value = SAMPLE_MIN;
    end else begin
      value = corrected[SAMPLE_W-1:0];
    end
  end

endmodule

### sv/imuoc_cal.sv
// Calibration accumulators, frame counter and per-axis offsets.
// Uses imuoc_pkg; offsets are the truncated-toward-zero window average.
module imuoc_cal #(
  parameter int CAL_SHIFT = imuoc_pkg::CAL_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  imuoc_pkg::sample_t raw    [imuoc_pkg::AXES],
  output imuoc_pkg::sample_t offset [imuoc_pkg::AXES]
);
  import imuoc_pkg::*;

  localparam int SUM_W = SAMPLE_W + CAL_SHIFT;
  localparam int CNT_W = CAL_SHIFT + 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'((1 << CAL_SHIFT) - 1);
  localparam logic signed [SUM_W:0] RND = (SUM_W+1)'((1 << CAL_SHIFT) - 1);

  logic [CNT_W-1:0]        cal_frames;
  logic signed [SUM_W-1:0] cal_sum      [AXES];
  logic signed [SUM_W-1:0] cal_sum_next [AXES];
  logic signed [SUM_W:0]   biased       [AXES];
  logic signed [SUM_W:0]   shifted      [AXES];
  sample_t                 avg          [AXES];
  logic                    window_done;

  assign window_done = (cal_frames == LAST);

  for (genvar i = 0; i < AXES; i++) begin : g_axis
    assign cal_sum_next[i] = cal_sum[i] + SUM_W'(raw[i]);
    // bias negative sums so the arithmetic shift truncates toward zero
    assign biased[i]  = (SUM_W+1)'(cal_sum_next[i]) +
                        (cal_sum_next[i][SUM_W-1] ? RND : '0);
    assign shifted[i] = biased[i] >>> CAL_SHIFT;
    assign avg[i]     = shifted[i][SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_frames <= '0;
      for (int i = 0; i < AXES; i++) begin
        cal_sum[i] <= '0;
        offset[i]  <= '0;
      end
    end else if (en) begin
      if (window_done) begin
        cal_frames <= '0;
        for (int i = 0; i < AXES; i++) begin
          cal_sum[i] <= '0;
          offset[i]  <= avg[i];
        end
      end else begin
        cal_frames <= cal_frames + 1'b1;
        for (int i = 0; i < AXES; i++) begin
          cal_sum[i] <= cal_sum_next[i];
        end
      end
    end
  end

endmodule

### sv/imu_offset_calibrate_and_correct.sv
// Top level of the six-axis IMU offset calibration and correction block.
// Uses imuoc_pkg, the imuoc interfaces, imuoc_cal, imuoc_axis and the defines header.
//
// Usage:
//   frame  (sink)  : one six-axis raw frame per transaction. req_type
//                    calibrate frames feed the averaging window and give no
//                    result; measure frames give exactly one result.
//   result (source): corrected, clamped axes plus accel/gyro saturation flags.
//   cfg    (sink)  : register writes (index, data); always ready. Write only
//                    while the block is idle.
// Path: a measure frame is captured in the input register, then loaded into the
//   result register, from which it is presented on result.
// Throughput: one frame per cycle. Calibrate frames retire out of the input
//   register at once; measure frames move on whenever the result register is
//   empty or being taken the same cycle.
// Stall: when result is held off, one measure frame waits in the result
//   register and one more in the input register; frame.ready then drops.
// Reset (rst, synchronous): registers take their documented defaults,
//   offsets, accumulators and the window count clear, both stages empty.
`include "imu_offset_calibrate_and_correct_defines.svh"

module imu_offset_calibrate_and_correct #(
  parameter int CAL_SHIFT = imuoc_pkg::CAL_SHIFT_DEF
) (
  input  logic  clk,
  input  logic  rst,
  imuoc_frame_if.sink    frame,
  imuoc_result_if.source result,
  imuoc_cfg_if.sink      cfg
);
  import imuoc_pkg::*;

  // ---------------- configuration registers ----------------
  limit_t              accel_limit;
  limit_t              gyro_limit;
  sample_t             gravity_counts;
  logic [NEGATE_W-1:0] axis_negate;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_limit    <= ACCEL_LIMIT_RST;
      gyro_limit     <= GYRO_LIMIT_RST;
      gravity_counts <= GRAVITY_RST;
      axis_negate    <= NEGATE_RST;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_ACCEL_LIMIT: accel_limit    <= cfg.data[LIMIT_W-1:0];
        REG_GYRO_LIMIT:  gyro_limit     <= cfg.data[LIMIT_W-1:0];
        REG_GRAVITY:     gravity_counts <= cfg.data;
        REG_AXIS_NEGATE: axis_negate    <= cfg.data[NEGATE_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ---------------- input register ----------------
  logic    s1_valid;
  logic    s1_valid_next;
  req_t    s1_req;
  sample_t s1_raw [AXES];
  logic    s1_advance;
  logic    s1_cal;
  logic    s1_meas;
  logic    frame_take;

  // result register
  logic    out_valid;
  logic    out_valid_next;

  assign s1_cal     = s1_valid && (s1_req == REQ_CAL);
  assign s1_meas    = s1_valid && (s1_req == REQ_MEASURE);
  // calibrate frames never wait on the result side
  assign s1_advance = s1_cal || (s1_meas && (!out_valid || result.ready));
  assign frame.ready = !s1_valid || s1_advance;
  assign frame_take  = frame.valid && frame.ready;

  always_comb begin
    s1_valid_next = s1_valid;
    if (frame_take) begin
      s1_valid_next = 1'b1;
    end else if (s1_advance) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      s1_req    <= req_t'(frame.req_type);
      s1_raw[0] <= frame.accel_x_raw;
      s1_raw[1] <= frame.accel_y_raw;
      s1_raw[2] <= frame.accel_z_raw;
      s1_raw[3] <= frame.roll_rate_raw;
      s1_raw[4] <= frame.pitch_rate_raw;
      s1_raw[5] <= frame.yaw_rate_raw;
    end
  end

  // ---------------- calibration ----------------
  sample_t offset [AXES];

  imuoc_cal #(
    .CAL_SHIFT(CAL_SHIFT)
  ) u_cal (
    .clk   (clk),
    .rst   (rst),
    .en    (s1_cal),
    .raw   (s1_raw),
    .offset(offset)
  );

  // ---------------- correction lanes ----------------
  axis_cfg_t lane_cfg [AXES];
  sample_t   lane_val [AXES];
  logic [AXES-1:0] lane_sat;

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    assign lane_cfg[i].negate  = axis_negate[i];
    assign lane_cfg[i].gravity = (i == AXIS_ACCEL_Z) ? gravity_counts : '0;
    assign lane_cfg[i].limit   = (i < ACCEL_AXES) ? accel_limit : gyro_limit;

    imuoc_axis u_axis (
      .raw   (s1_raw[i]),
      .offset(offset[i]),
      .cfg   (lane_cfg[i]),
      .value (lane_val[i]),
      .sat   (lane_sat[i])
    );
  end

  // ---------------- result register ----------------
  logic out_load;

  assign out_load = s1_meas && s1_advance;

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (result.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.accel_x_out      <= lane_val[0];
      result.accel_y_out      <= lane_val[1];
      result.accel_z_out      <= lane_val[2];
      result.roll_rate_out    <= lane_val[3];
      result.pitch_rate_out   <= lane_val[4];
      result.yaw_rate_out     <= lane_val[5];
      result.accel_over_limit <= |lane_sat[ACCEL_AXES-1:0];
      result.gyro_over_limit  <= |lane_sat[AXES-1:ACCEL_AXES];
    end
  end

  assign result.valid = out_valid;

  // ---------------- assertions ----------------
  // an empty input register always takes a frame
  `IMUOC_ASSERT_IMP(a_empty_ready, clk, rst, !s1_valid, frame.ready)
  // a calibrate frame never holds up the input side
  `IMUOC_ASSERT_IMP(a_cal_no_block, clk, rst, s1_cal, frame.ready)
  // a measure frame blocked by a stalled result stays in the input register
  `IMUOC_ASSERT_NXT(a_meas_holds, clk, rst, s1_meas && out_valid && !result.ready,
                    s1_valid && (s1_req == REQ_MEASURE))
  // a result only appears after a measure frame left the input register
  `IMUOC_ASSERT_IMP(a_out_from_meas, clk, rst, $rose(out_valid),
                    $past(s1_meas))

endmodule

### verif/tb_top.sv
// Self-checking testbench for imu_offset_calibrate_and_correct: directed and random
// frames, register sweeps and back-pressure, each result checked against a built-in model.
// Depends on imuoc_pkg, the imuoc interfaces and the RTL of the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import imuoc_pkg::*;

  localparam int CAL_SHIFT   = CAL_SHIFT_DEF;
  localparam int CAL_FRAMES  = 1 << CAL_SHIFT;  // frames per averaging window
  localparam int PIPE_DEPTH  = 2;               // input reg + result reg
  localparam int MAX_GAP     = 17;              // longest idle/stall drawn per transaction
  localparam int CYCLE_LIMIT = 600000;          // watchdog
  localparam int CLK_HALF    = 4;               // 8 ns period
  localparam int RESET_CYCLES = 11;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP = '1;

  typedef sample_t axis_vec_t [AXES];

  // One corrected frame as the block should present it.
  typedef struct {
    sample_t axis [AXES];
    logic    accel_sat;
    logic    gyro_sat;
  } corrected_t;

  logic clk;
  logic rst;

  imuoc_frame_if  frame_ch ();
  imuoc_result_if res_ch ();
  imuoc_cfg_if    cfg_ch ();

  imu_offset_calibrate_and_correct #(
    .CAL_SHIFT(CAL_SHIFT)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .frame (frame_ch),
    .result(res_ch),
    .cfg   (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // ---------------------------------------------------------------------------
  // Correction model: its own copy of offsets, window accumulators and registers.
  // ---------------------------------------------------------------------------
  sample_t             cal_offset [AXES];
  int                  cal_acc [AXES];     // 16 frames of int16 fit easily in an int
  int                  cal_count;
  limit_t              accel_lim;
  limit_t              gyro_lim;
  sample_t             gravity;
  logic [NEGATE_W-1:0] negate_mask;

  corrected_t expected_q [$];   // corrected frames still owed by the block

  // Run statistics and verdict.
  int fail_count;
  int frames_sent;
  int cal_sent;
  int windows_closed;
  int results_checked;
  int accel_flags;
  int gyro_flags;
  int reg_writes;
  int cycle_count;

  // Idle shaping: a steady side never inserts gaps.
  bit send_steady;
  bit recv_steady;

  function automatic void model_reset();
    for (int i = 0; i < AXES; i++) begin
      cal_offset[i] = '0;
      cal_acc[i]    = 0;
    end
    cal_count   = 0;
    accel_lim   = ACCEL_LIMIT_RST;
    gyro_lim    = GYRO_LIMIT_RST;
    gravity     = GRAVITY_RST;
    negate_mask = NEGATE_RST;
  endfunction

  // Register write as the block applies it: masked to width, unknown index dropped.
  function automatic void model_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_ACCEL_LIMIT: accel_lim   = value[LIMIT_W-1:0];
      REG_GYRO_LIMIT:  gyro_lim    = value[LIMIT_W-1:0];
      REG_GRAVITY:     gravity     = sample_t'(value);
      REG_AXIS_NEGATE: negate_mask = value[NEGATE_W-1:0];
      default: ;
    endcase
  endfunction

  // Calibrate frame: accumulate; the last frame of a window sets the offsets.
  function automatic void model_accumulate(axis_vec_t raw);
    for (int i = 0; i < AXES; i++)
      cal_acc[i] += int'(raw[i]);
    cal_count++;
    if (cal_count >= CAL_FRAMES) begin
      // SV integer division truncates toward zero, as the block must
      for (int i = 0; i < AXES; i++) begin
        cal_offset[i] = sample_t'(cal_acc[i] / CAL_FRAMES);
        cal_acc[i]    = 0;
      end
      cal_count = 0;
      windows_closed++;
    end
  endfunction

  // Measure frame: subtract offset, optional negate, gravity on Z, wide compare, clamp.
  function automatic corrected_t model_correct(axis_vec_t raw);
    corrected_t r;
    int v;
    int lim;
    r.accel_sat = 1'b0;
    r.gyro_sat  = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      v = int'(raw[i]) - int'(cal_offset[i]);
      if (negate_mask[i])
        v = -v;
      if (i == AXIS_ACCEL_Z)
        v += int'(gravity);
      lim = (i < ACCEL_AXES) ? int'(accel_lim) : int'(gyro_lim);
      if (v > lim || v < -lim) begin
        if (i < ACCEL_AXES)
          r.accel_sat = 1'b1;
        else
          r.gyro_sat = 1'b1;
      end
      if (v > int'(SAMPLE_MAX))
        v = int'(SAMPLE_MAX);
      else if (v < int'(SAMPLE_MIN))
        v = int'(SAMPLE_MIN);
      r.axis[i] = sample_t'(v);
    end
    return r;
  endfunction

  function automatic string axis_name(int i);
    case (i)
      0:       return "accel_x_out";
      1:       return "accel_y_out";
      2:       return "accel_z_out";
      3:       return "roll_rate_out";
      4:       return "pitch_rate_out";
      default: return "yaw_rate_out";
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 5))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return sample_t'(int'($urandom_range(0, 2)) - 1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Measure samples cluster around the held offset so both flag outcomes occur.
  function automatic sample_t measure_sample(int i);
    case ($urandom_range(0, 3))
      0:       return pick_sample();
      1:       return sample_t'(int'(cal_offset[i]) + int'($urandom_range(0, 1200)) - 600);
      2:       return sample_t'(int'(cal_offset[i]) + int'($urandom_range(0, 24000)) - 12000);
      default: return sample_t'(int'($urandom_range(0, 1400)) - 700);
    endcase
  endfunction

  function automatic limit_t pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return limit_t'($urandom_range(0, 800));
      3:       return limit_t'($urandom_range(0, 8000));
      default: return limit_t'($urandom);
    endcase
  endfunction

  function automatic sample_t pick_gravity();
    case ($urandom_range(0, 3))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return GRAVITY_RST;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [NEGATE_W-1:0] pick_negate();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return NEGATE_W'($urandom);
    endcase
  endfunction

  function automatic int draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // ---------------------------------------------------------------------------
  // Frame and register drivers
  // ---------------------------------------------------------------------------

  // One frame transaction. valid is dropped only when a gap is drawn, so it never
  // gets two NBAs in one step; the model is updated at the accepting edge.
  task automatic send_frame(input req_t kind, input axis_vec_t raw);
    int gap;
    corrected_t r;
    gap = draw_gap(send_steady);
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_ch.valid          <= 1'b1;
    frame_ch.req_type       <= kind;
    frame_ch.accel_x_raw    <= raw[0];
    frame_ch.accel_y_raw    <= raw[1];
    frame_ch.accel_z_raw    <= raw[2];
    frame_ch.roll_rate_raw  <= raw[3];
    frame_ch.pitch_rate_raw <= raw[4];
    frame_ch.yaw_rate_raw   <= raw[5];
    do @(posedge clk); while (!frame_ch.ready);
    frames_sent++;
    if (kind == REQ_CAL) begin
      cal_sent++;
      model_accumulate(raw);
    end else begin
      r = model_correct(raw);
      if (r.accel_sat)
        accel_flags++;
      if (r.gyro_sat)
        gyro_flags++;
      expected_q.push_back(r);
    end
  endtask

  // Stop sending and hold until every owed result has been taken.
  task automatic drain_results();
    frame_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // Calibrate frames give no result, so allow the pipe to empty after the drain.
  task automatic wait_idle();
    drain_results();
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes; caller lowers it at the end.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    reg_writes++;
    model_reg_write(idx, value);
  endtask

  // Program all four registers, with junk in the unused upper bits, plus a write
  // to an index past the register list that must be ignored.
  task automatic program_regs(input limit_t a_lim, input limit_t g_lim, input sample_t grav,
                              input logic [NEGATE_W-1:0] neg);
    logic [CFG_IDX_W-1:0] spare_idx;
    wait_idle();
    spare_idx = CFG_IDX_W'($urandom_range(int'(REG_AXIS_NEGATE) + 1, int'(REG_IDX_TOP)));
    write_reg(REG_ACCEL_LIMIT, {1'($urandom), a_lim});
    write_reg(REG_GYRO_LIMIT, {1'($urandom), g_lim});
    write_reg(REG_GRAVITY, grav);
    write_reg(REG_AXIS_NEGATE, {(CFG_DATA_W - NEGATE_W)'($urandom), neg});
    write_reg(spare_idx, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // n frames, roughly cal_pct percent of them calibrate frames.
  task automatic random_mix(input int n, input int cal_pct);
    axis_vec_t f;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < cal_pct) begin
        foreach (f[i]) f[i] = pick_sample();
        send_frame(REQ_CAL, f);
      end else begin
        foreach (f[i]) f[i] = measure_sample(i);
        send_frame(REQ_MEASURE, f);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers, zero offsets: limit edges (exactly at limit vs one past),
  // gravity on Z, full-scale samples that clamp.
  task automatic test_reset_defaults();
    axis_vec_t f;
    f = '{0, 0, 0, 0, 0, 0};
    send_frame(REQ_MEASURE, f);                // Z shows gravity only
    f = '{500, -500, 244, 5000, -5000, 5000};
    send_frame(REQ_MEASURE, f);                // every axis sits on its limit
    f = '{0, 0, 0, 0, 0, 5001};
    send_frame(REQ_MEASURE, f);                // negated yaw past limit: gyro flag only
    f = '{0, 501, 0, 0, 0, 0};
    send_frame(REQ_MEASURE, f);                // accel flag only
    foreach (f[i]) f[i] = SAMPLE_MAX;
    send_frame(REQ_MEASURE, f);                // Z + gravity overflows, clamps high
    foreach (f[i]) f[i] = SAMPLE_MIN;
    send_frame(REQ_MEASURE, f);                // negated min exceeds +32767
    drain_results();
  endtask

  // One full window with extreme sums and negative sums that must truncate toward
  // zero; a measure frame in mid-window still uses the old (zero) offsets.
  task automatic test_calibration_window();
    axis_vec_t f;
    for (int k = 0; k < CAL_FRAMES; k++) begin
      f[0] = SAMPLE_MIN;                       // offset -32768
      f[1] = SAMPLE_MAX;                       // offset +32767
      f[2] = (k == 0) ? -16'sd17 : 16'sd0;     // -17/16 -> -1, not -2
      f[3] = (k == 0) ? 16'sd31 : 16'sd0;      // 31/16 -> 1
      f[4] = k[0] ? SAMPLE_MIN : SAMPLE_MAX;   // sum -8 -> 0, not -1
      f[5] = pick_sample();
      send_frame(REQ_CAL, f);
      if (k == CAL_FRAMES / 2) begin
        f = '{0, 0, 0, 0, 0, 0};
        send_frame(REQ_MEASURE, f);
      end
    end
    // raw - offset reaches +/-65535 before negate and clamp
    foreach (f[i]) f[i] = SAMPLE_MAX;
    send_frame(REQ_MEASURE, f);
    foreach (f[i]) f[i] = SAMPLE_MIN;
    send_frame(REQ_MEASURE, f);
    drain_results();
  endtask

  // Register extremes, then back to reset values.
  task automatic test_register_sweep();
    program_regs('0, '0, SAMPLE_MIN, '0);
    random_mix(40, 25);
    program_regs('1, '1, SAMPLE_MAX, '1);
    random_mix(40, 25);
    program_regs('0, '1, 16'sd0, 6'b010101);
    random_mix(40, 25);
    program_regs('1, '0, -16'sd1, 6'b101010);
    random_mix(40, 25);
    program_regs(ACCEL_LIMIT_RST, GYRO_LIMIT_RST, GRAVITY_RST, NEGATE_RST);
    random_mix(40, 25);
  endtask

  // Phases of random settings. Mostly full calibration windows (bias plus noise)
  // and bursts of measure frames; some stray calibrate frames leave partial windows.
  task automatic test_random_traffic();
    axis_vec_t f;
    int bias [AXES];
    int sent;
    int burst;
    for (int p = 0; p < 14; p++) begin
      program_regs(pick_limit(), pick_limit(), pick_gravity(), pick_negate());
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 100) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            foreach (bias[i]) bias[i] = int'(pick_sample());
            for (int k = 0; k < CAL_FRAMES; k++) begin
              foreach (f[i]) f[i] = sample_t'(bias[i] + int'($urandom_range(0, 64)) - 32);
              send_frame(REQ_CAL, f);
            end
            sent += CAL_FRAMES;
          end
          9: begin
            burst = $urandom_range(1, 5);
            for (int k = 0; k < burst; k++) begin
              foreach (f[i]) f[i] = pick_sample();
              send_frame(REQ_CAL, f);
            end
            sent += burst;
          end
          default: begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) begin
              foreach (f[i]) f[i] = measure_sample(i);
              send_frame(REQ_MEASURE, f);
            end
            sent += burst;
          end
        endcase
      end
    end
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  // Sender holds off until all results are back, after groups sent at full rate
  // or with gaps, so the pipe both fills and empties under receiver stalls.
  task automatic test_drain_pause();
    program_regs(pick_limit(), pick_limit(), pick_gravity(), pick_negate());
    for (int g = 0; g < 10; g++) begin
      send_steady = g[0];
      random_mix(30, 20);
      drain_results();
    end
    send_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, and a check of every result transaction.
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      gap = draw_gap(recv_steady);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  always @(posedge clk) begin : result_check
    corrected_t want;
    sample_t    got [AXES];
    if (!rst && res_ch.valid && res_ch.ready) begin
      got[0] = res_ch.accel_x_out;
      got[1] = res_ch.accel_y_out;
      got[2] = res_ch.accel_z_out;
      got[3] = res_ch.roll_rate_out;
      got[4] = res_ch.pitch_rate_out;
      got[5] = res_ch.yaw_rate_out;
      if (expected_q.size() == 0) begin
        $error("result transaction with no measure frame outstanding");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        for (int i = 0; i < AXES; i++) begin
          if (got[i] !== want.axis[i]) begin
            $error("%s: expected %0d, got %0d", axis_name(i), want.axis[i], got[i]);
            fail_count++;
          end
        end
        if (res_ch.accel_over_limit !== want.accel_sat) begin
          $error("accel_over_limit: expected %0b, got %0b", want.accel_sat,
                 res_ch.accel_over_limit);
          fail_count++;
        end
        if (res_ch.gyro_over_limit !== want.gyro_sat) begin
          $error("gyro_over_limit: expected %0b, got %0b", want.gyro_sat,
                 res_ch.gyro_over_limit);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    model_reset();
    fail_count      = 0;
    frames_sent     = 0;
    cal_sent        = 0;
    windows_closed  = 0;
    results_checked = 0;
    accel_flags     = 0;
    gyro_flags      = 0;
    reg_writes      = 0;
    cycle_count     = 0;
    send_steady     = 1'b0;
    recv_steady     = 1'b0;

    frame_ch.valid          = 1'b0;
    frame_ch.req_type       = REQ_CAL;
    frame_ch.accel_x_raw    = '0;
    frame_ch.accel_y_raw    = '0;
    frame_ch.accel_z_raw    = '0;
    frame_ch.roll_rate_raw  = '0;
    frame_ch.pitch_rate_raw = '0;
    frame_ch.yaw_rate_raw   = '0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = '0;
    cfg_ch.data             = '0;

    rst = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_calibration_window();
    test_register_sweep();
    test_random_traffic();
    test_drain_pause();

    // all results back, then keep clocking to catch anything extra
    wait_idle();
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    $display("Covered %0d frames (%0d calibrate, %0d windows closed), %0d register writes.",
             frames_sent, cal_sent, windows_closed, reg_writes);
    $display("Checked %0d corrected results: %0d with accel and %0d with gyro saturation.",
             results_checked, accel_flags, gyro_flags);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
